// ===== src/rpvc_pkg.sv =====
// Shared types, codes and defaults of the rectangle polygon vertex clipper.
package rpvc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_PTS         = 7;
    localparam int NUM_JOBS        = 9;

    localparam longint CLIP_LEFT_RST   = 0;
    localparam longint CLIP_RIGHT_RST  = 163840;
    localparam longint CLIP_TOP_RST    = 0;
    localparam longint CLIP_BOTTOM_RST = 122880;

    typedef logic [3:0] region_t;
    typedef logic [1:0] cfg_idx_t;
    typedef logic [3:0] job_t;

    localparam region_t RG_TL = 4'd0;
    localparam region_t RG_T  = 4'd1;
    localparam region_t RG_TR = 4'd2;
    localparam region_t RG_L  = 4'd3;
    localparam region_t RG_IN = 4'd4;
    localparam region_t RG_R  = 4'd5;
    localparam region_t RG_BL = 4'd6;
    localparam region_t RG_B  = 4'd7;
    localparam region_t RG_BR = 4'd8;

    localparam cfg_idx_t CFG_LEFT   = 2'd0;
    localparam cfg_idx_t CFG_RIGHT  = 2'd1;
    localparam cfg_idx_t CFG_TOP    = 2'd2;
    localparam cfg_idx_t CFG_BOTTOM = 2'd3;

    localparam job_t JOB_TB    = 4'd0;
    localparam job_t JOB_BB    = 4'd1;
    localparam job_t JOB_LB    = 4'd2;
    localparam job_t JOB_RB    = 4'd3;
    localparam job_t JOB_TC    = 4'd4;
    localparam job_t JOB_BC    = 4'd5;
    localparam job_t JOB_LC    = 4'd6;
    localparam job_t JOB_RC    = 4'd7;
    localparam job_t JOB_CHAIN = 4'd8;

    typedef struct packed {
        region_t cur;
        region_t prv;
    } reg_pair_t;

endpackage

// ===== src/rpvc_muldiv.sv =====
// Shared serial unit: base + a*b/c, truncated quotient, saturated sum.
module rpvc_muldiv #(
    parameter int W = rpvc_pkg::COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W:0]   a,
    input  logic signed [W:0]   b,
    input  logic signed [W:0]   c,
    input  logic signed [W-1:0] base,
    output logic                done,
    output logic signed [W-1:0] result
);
    import rpvc_pkg::*;

    localparam int M  = W + 1;
    localparam int P  = 2 * M;
    localparam int CW = $clog2(P);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [P-1:0]   CAP  = P'(1) << W;
    localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [P-1:0]        acc_reg, acc_next;
    logic [P-1:0]        mcand_reg, mcand_next;
    logic [M-1:0]        mplier_reg, mplier_next;
    logic [M-1:0]        cm_reg, cm_next;
    logic [M-1:0]        rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                ovf_reg, ovf_next;
    logic signed [W-1:0] base_reg, base_next;
    logic signed [W-1:0] result_reg, result_next;
    logic                done_reg, done_next;

    logic [M-1:0]        am, bm, cmag;
    logic [P-1:0]        acc_add;
    logic [M:0]          rem_sh;
    logic [W:0]          qm;
    logic signed [W+1:0] sum;

    always_comb
    begin
        am      = a[W] ? M'(-a) : M'(a);
        bm      = b[W] ? M'(-b) : M'(b);
        cmag    = c[W] ? M'(-c) : M'(c);
        acc_add = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        rem_sh  = {rem_reg, acc_reg[P-1]};
        if (ovf_reg || acc_reg > CAP)
        begin
            qm = CAP[W:0];
        end
        else
        begin
            qm = acc_reg[W:0];
        end
        sum = {{2{base_reg[W-1]}}, base_reg}
            + (neg_reg ? -$signed({1'b0, qm}) : $signed({1'b0, qm}));
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cm_next     = cm_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        base_next   = base_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = P'(am);
                    mplier_next = bm;
                    cm_next     = cmag;
                    neg_next    = a[W] ^ b[W] ^ c[W];
                    ovf_next    = 1'b0;
                    base_next   = base;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next    = acc_add;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(M - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (acc_add == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (cm_reg == '0)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, cm_reg})
                begin
                    rem_next = M'(rem_sh - {1'b0, cm_reg});
                    acc_next = {acc_reg[P-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[M-1:0];
                    acc_next = {acc_reg[P-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(P - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sum > SMAX)
                begin
                    result_next = SMAX[W-1:0];
                end
                else if (sum < SMIN)
                begin
                    result_next = SMIN[W-1:0];
                end
                else
                begin
                    result_next = sum[W-1:0];
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cm_reg     <= cm_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        base_reg   <= base_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/rpvc_emit.sv =====
// Point list builder: border crossings and corners for one region change.
module rpvc_emit #(
    parameter int W = rpvc_pkg::COORD_WIDTH_DEF
) (
    input  rpvc_pkg::reg_pair_t pair,
    input  logic signed [W-1:0] cl,
    input  logic signed [W-1:0] cr,
    input  logic signed [W-1:0] ct,
    input  logic signed [W-1:0] cb,
    input  logic signed [W-1:0] vx,
    input  logic signed [W-1:0] vy,
    input  logic signed [W-1:0] tb,
    input  logic signed [W-1:0] bb,
    input  logic signed [W-1:0] lb,
    input  logic signed [W-1:0] rb,
    input  logic signed [W-1:0] tc,
    input  logic signed [W-1:0] bc,
    input  logic signed [W-1:0] lc,
    input  logic signed [W-1:0] rc,
    input  logic signed [W-1:0] chn,
    output logic signed [W-1:0] px [rpvc_pkg::MAX_PTS],
    output logic signed [W-1:0] py [rpvc_pkg::MAX_PTS],
    output logic [2:0]          cnt
);
    import rpvc_pkg::*;

    logic [2:0]          n;
    region_t             off;
    logic signed [W-1:0] sx, sy, kx, ky;

    always_comb
    begin
        n = '0;
        for (int i = 0; i < MAX_PTS; i++)
        begin
            px[i] = '0;
            py[i] = '0;
        end
        off = (pair.cur == RG_IN) ? pair.prv : pair.cur;
        sx  = (off == RG_TL || off == RG_TR) ? tb : bb;
        sy  = (off == RG_TL || off == RG_TR) ? ct : cb;
        kx  = (off == RG_TL || off == RG_BL) ? cl : cr;
        ky  = (off == RG_TL || off == RG_TR) ? ct : cb;
        if ((off == RG_TL || off == RG_BL) && sx < cl)
        begin
            sx = cl;
            sy = chn;
        end
        if ((off == RG_TR || off == RG_BR) && sx > cr)
        begin
            sx = cr;
            sy = chn;
        end

        if (pair.cur != pair.prv && (pair.cur == RG_IN || pair.prv == RG_IN))
        begin
            case (off)
                RG_TL, RG_TR, RG_BL, RG_BR:
                begin
                    if (pair.cur == RG_IN)
                    begin
                        px[n] = kx; py[n] = ky; n = n + 3'd1;
                        px[n] = sx; py[n] = sy; n = n + 3'd1;
                    end
                    else
                    begin
                        px[n] = sx; py[n] = sy; n = n + 3'd1;
                        px[n] = kx; py[n] = ky; n = n + 3'd1;
                    end
                end
                RG_T:
                begin
                    px[n] = tb; py[n] = ct; n = n + 3'd1;
                end
                RG_L:
                begin
                    px[n] = cl; py[n] = lb; n = n + 3'd1;
                end
                RG_R:
                begin
                    px[n] = cr; py[n] = rb; n = n + 3'd1;
                end
                RG_B:
                begin
                    px[n] = bb; py[n] = cb; n = n + 3'd1;
                end
                default:
                begin
                end
            endcase
        end
        else if (pair.cur != pair.prv)
        begin
            case (pair.cur)
                RG_TL:
                begin
                    if (pair.prv == RG_R)
                    begin
                        if (rb > ct) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                        if (tc >= cl && tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_B)
                    begin
                        if (bb > cl) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                        if (lc >= ct && lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (tc > cl) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_BR)
                    begin
                        if (bb > cl && bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (rb > ct && rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (tc > cl && tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct && lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (bb <= cl && lc >= cb) begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                        if (tc >= cr && rb <= ct) begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                    end
                    px[n] = cl; py[n] = ct; n = n + 3'd1;
                end
                RG_T:
                begin
                    if (pair.prv == RG_L)
                    begin
                        if (lb > ct) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                        if (tc > cl) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_R)
                    begin
                        if (rb > ct) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                        if (tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_BL)
                    begin
                        if (bb > cl) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (lb > ct && lb <= cb) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        if (tc > cl) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_B)
                    begin
                        px[n] = bb; py[n] = cb; n = n + 3'd1;
                        px[n] = tc; py[n] = ct; n = n + 3'd1;
                    end
                    else if (pair.prv == RG_BR)
                    begin
                        if (bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (rb > ct && rb <= cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                    end
                end
                RG_TR:
                begin
                    if (pair.prv == RG_L)
                    begin
                        if (lb > ct) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                        if (tc > cl && tc <= cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (rc > ct) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_B)
                    begin
                        if (bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                        if (rc >= ct && rc < cb) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        if (tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_BL)
                    begin
                        if (bb > cl && bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (lc > ct && lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (tc > cl && tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (rb > ct && rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (bb >= cr && rb >= cb) begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                        if (tc <= cl && lc <= ct) begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                    end
                    px[n] = cr; py[n] = ct; n = n + 3'd1;
                end
                RG_L:
                begin
                    if (pair.prv == RG_B)
                    begin
                        if (bb > cl) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_T)
                    begin
                        if (tb > cl) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_BR)
                    begin
                        if (rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (bb > cl && bb <= cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_R)
                    begin
                        px[n] = cr; py[n] = rb; n = n + 3'd1;
                        px[n] = cl; py[n] = lc; n = n + 3'd1;
                    end
                    else if (pair.prv == RG_TR)
                    begin
                        if (rb > ct) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (tb > cl && tb <= cr) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                    end
                end
                RG_R:
                begin
                    if (pair.prv == RG_B)
                    begin
                        if (bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (rc < cb) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_T)
                    begin
                        if (tb < cr) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (rc > ct) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_BL)
                    begin
                        if (lb < cb) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        if (bb >= cl && bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (rc < cb) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_L)
                    begin
                        px[n] = cl; py[n] = lb; n = n + 3'd1;
                        px[n] = cr; py[n] = rc; n = n + 3'd1;
                    end
                    else if (pair.prv == RG_TL)
                    begin
                        if (lb > ct) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        if (tb >= cl && tb < cr) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (rc > ct) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                    end
                end
                RG_BL:
                begin
                    if (pair.prv == RG_R)
                    begin
                        if (rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                        if (bc >= cl && bc < cr) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                        if (lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_T)
                    begin
                        if (tb > cl) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct && lc <= cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (bc > cl) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_TR)
                    begin
                        if (tc > cl && tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (rb > ct && rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (bb > cl && bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (lc > ct && lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (bb >= cr && rb >= cb) begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                        if (tc <= cl && lc <= ct) begin px[n] = cl; py[n] = ct; n = n + 3'd1; end
                    end
                    px[n] = cl; py[n] = cb; n = n + 3'd1;
                end
                RG_B:
                begin
                    if (pair.prv == RG_L)
                    begin
                        if (lb < cb) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                        if (bc > cl) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_R)
                    begin
                        if (rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                        if (bc < cr) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_TL)
                    begin
                        if (tb > cl) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (lb >= ct && lb < cb) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        if (bc > cl) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_T)
                    begin
                        px[n] = tb; py[n] = ct; n = n + 3'd1;
                        px[n] = bc; py[n] = cb; n = n + 3'd1;
                    end
                    else if (pair.prv == RG_TR)
                    begin
                        if (tb < cr) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        if (rb >= ct && rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (bc < cr) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = cb; n = n + 3'd1; end
                    end
                end
                RG_BR:
                begin
                    if (pair.prv == RG_L)
                    begin
                        if (lb < cb) begin px[n] = cl; py[n] = lb; n = n + 3'd1; end
                        else begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                        if (bc > cl && bc <= cr) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                        if (rc < cb) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_T)
                    begin
                        if (tb < cr) begin px[n] = tb; py[n] = ct; n = n + 3'd1; end
                        else begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                        if (rc > ct && rc <= cb) begin px[n] = cr; py[n] = rc; n = n + 3'd1; end
                        if (bc < cr) begin px[n] = bc; py[n] = cb; n = n + 3'd1; end
                    end
                    else if (pair.prv == RG_TL)
                    begin
                        if (tc > cl && tc < cr) begin px[n] = tc; py[n] = ct; n = n + 3'd1; end
                        if (lc > ct && lc < cb) begin px[n] = cl; py[n] = lc; n = n + 3'd1; end
                        if (bb > cl && bb < cr) begin px[n] = bb; py[n] = cb; n = n + 3'd1; end
                        if (rb > ct && rb < cb) begin px[n] = cr; py[n] = rb; n = n + 3'd1; end
                        if (bb <= cl && lc >= cb) begin px[n] = cl; py[n] = cb; n = n + 3'd1; end
                        if (tc >= cr && rb <= ct) begin px[n] = cr; py[n] = ct; n = n + 3'd1; end
                    end
                    px[n] = cr; py[n] = cb; n = n + 3'd1;
                end
                default:
                begin
                end
            endcase
        end

        if (pair.cur == RG_IN)
        begin
            px[n] = vx; py[n] = vy; n = n + 3'd1;
        end
        cnt = n;
    end

endmodule

// ===== src/rect_polygon_vertex_clipper.sv =====
// Polygon vertex clipper against a rectangle: sequencer, state and output buffer.
//
// Takes one vertex word at a time and returns 0 to 7 clipped points, the last
// one of each vertex marked by m_tlast. A vertex that changes region runs
// nine crossing jobs through the single shared multiply/divide unit, each
// made of a start step, a bit-serial multiply of COORD_WIDTH+1 steps, a
// restoring divide of 2*COORD_WIDTH+2 steps, a saturate step and a step to
// hand the result back; a zero product or a zero divisor skips the divide.
// s_tready is low from accept until the last point is taken, or until the
// build when no point results.
module rect_polygon_vertex_clipper #(
    parameter int COORD_WIDTH = rpvc_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vx, vy, zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // first_vertex
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ox, oy, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  rpvc_pkg::cfg_idx_t                cfg_addr,
    input  logic [COORD_WIDTH-1:0]            cfg_wdata
);
    import rpvc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((2 * W + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GO    = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_BUILD = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;

    logic [2:0]          state_reg, state_next;
    job_t                job_reg, job_next;
    logic signed [W-1:0] cl_reg, cr_reg, ct_reg, cb_reg;
    logic signed [W-1:0] px_reg, py_reg;
    region_t             prev_region_reg;
    logic signed [W-1:0] cx_reg, cy_reg;
    logic signed [W:0]   dx_reg, dy_reg;
    reg_pair_t           pair_reg;
    logic signed [W-1:0] res_reg [NUM_JOBS];
    logic signed [W-1:0] obx_reg [MAX_PTS];
    logic signed [W-1:0] oby_reg [MAX_PTS];
    logic [2:0]          ocnt_reg, oidx_reg;

    logic signed [W-1:0] in_x, in_y;
    logic [1:0]          col;
    region_t             row, cur_in;
    logic                accept;
    logic signed [W:0]   dx_in, dy_in;

    logic                mu_start, mu_done;
    logic signed [W:0]   mu_a, mu_b, mu_c;
    logic signed [W-1:0] mu_base, mu_result;
    region_t             off;
    logic signed [W-1:0] ch_x, ch_e;

    logic signed [W-1:0] lpx [MAX_PTS];
    logic signed [W-1:0] lpy [MAX_PTS];
    logic [2:0]          lcnt;

    assign in_x   = s_tdata[W-1:0];
    assign in_y   = s_tdata[2*W-1:W];
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        if (in_x < cl_reg)
        begin
            col = 2'd0;
        end
        else if (in_x > cr_reg)
        begin
            col = 2'd2;
        end
        else
        begin
            col = 2'd1;
        end
        if (in_y < ct_reg)
        begin
            row = 4'd0;
        end
        else if (in_y > cb_reg)
        begin
            row = 4'd6;
        end
        else
        begin
            row = 4'd3;
        end
        cur_in = row + {2'b00, col};
        dx_in  = {in_x[W-1], in_x} - {px_reg[W-1], px_reg};
        dy_in  = {in_y[W-1], in_y} - {py_reg[W-1], py_reg};
        if (dx_in == '0)
        begin
            dx_in = (W+1)'(1);
        end
    end

    always_comb
    begin
        off  = (pair_reg.cur == RG_IN) ? pair_reg.prv : pair_reg.cur;
        ch_x = (off == RG_TL || off == RG_TR) ? res_reg[JOB_TB] : res_reg[JOB_BB];
        ch_e = (off == RG_TL || off == RG_BL) ? cl_reg : cr_reg;
        mu_b = dy_reg;
        mu_c = dx_reg;
        unique case (job_reg)
            JOB_TB:
            begin
                mu_a = {ct_reg[W-1], ct_reg} - {py_reg[W-1], py_reg};
                mu_b = dx_reg; mu_c = dy_reg; mu_base = px_reg;
            end
            JOB_BB:
            begin
                mu_a = {cb_reg[W-1], cb_reg} - {py_reg[W-1], py_reg};
                mu_b = dx_reg; mu_c = dy_reg; mu_base = px_reg;
            end
            JOB_LB:
            begin
                mu_a = {cl_reg[W-1], cl_reg} - {px_reg[W-1], px_reg};
                mu_base = py_reg;
            end
            JOB_RB:
            begin
                mu_a = {cr_reg[W-1], cr_reg} - {px_reg[W-1], px_reg};
                mu_base = py_reg;
            end
            JOB_TC:
            begin
                mu_a = {ct_reg[W-1], ct_reg} - {cy_reg[W-1], cy_reg};
                mu_b = dx_reg; mu_c = dy_reg; mu_base = cx_reg;
            end
            JOB_BC:
            begin
                mu_a = {cb_reg[W-1], cb_reg} - {cy_reg[W-1], cy_reg};
                mu_b = dx_reg; mu_c = dy_reg; mu_base = cx_reg;
            end
            JOB_LC:
            begin
                mu_a = {cl_reg[W-1], cl_reg} - {cx_reg[W-1], cx_reg};
                mu_base = cy_reg;
            end
            JOB_RC:
            begin
                mu_a = {cr_reg[W-1], cr_reg} - {cx_reg[W-1], cx_reg};
                mu_base = cy_reg;
            end
            default:
            begin
                mu_a    = {ch_e[W-1], ch_e} - {ch_x[W-1], ch_x};
                mu_base = (off == RG_TL || off == RG_TR) ? ct_reg : cb_reg;
            end
        endcase
    end

    assign mu_start = (state_reg == ST_GO);

    rpvc_muldiv #(
        .W(W)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mu_start),
        .a      (mu_a),
        .b      (mu_b),
        .c      (mu_c),
        .base   (mu_base),
        .done   (mu_done),
        .result (mu_result)
    );

    rpvc_emit #(
        .W(W)
    ) u_emit (
        .pair (pair_reg),
        .cl   (cl_reg),
        .cr   (cr_reg),
        .ct   (ct_reg),
        .cb   (cb_reg),
        .vx   (cx_reg),
        .vy   (cy_reg),
        .tb   (res_reg[JOB_TB]),
        .bb   (res_reg[JOB_BB]),
        .lb   (res_reg[JOB_LB]),
        .rb   (res_reg[JOB_RB]),
        .tc   (res_reg[JOB_TC]),
        .bc   (res_reg[JOB_BC]),
        .lc   (res_reg[JOB_LC]),
        .rc   (res_reg[JOB_RC]),
        .chn  (res_reg[JOB_CHAIN]),
        .px   (lpx),
        .py   (lpy),
        .cnt  (lcnt)
    );

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    job_next = JOB_TB;
                    if (!s_tuser && cur_in != prev_region_reg)
                    begin
                        state_next = ST_GO;
                    end
                    else
                    begin
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mu_done)
                begin
                    if (job_reg == JOB_CHAIN)
                    begin
                        state_next = ST_BUILD;
                    end
                    else
                    begin
                        job_next   = job_reg + 1'b1;
                        state_next = ST_GO;
                    end
                end
            end
            ST_BUILD:
            begin
                state_next = (lcnt == '0) ? ST_IDLE : ST_SEND;
            end
            ST_SEND:
            begin
                if (m_tready && oidx_reg == ocnt_reg - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            job_reg         <= JOB_TB;
            cl_reg          <= W'(CLIP_LEFT_RST);
            cr_reg          <= W'(CLIP_RIGHT_RST);
            ct_reg          <= W'(CLIP_TOP_RST);
            cb_reg          <= W'(CLIP_BOTTOM_RST);
            px_reg          <= '0;
            py_reg          <= '0;
            prev_region_reg <= RG_IN;
            ocnt_reg        <= '0;
            oidx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_LEFT:   cl_reg <= cfg_wdata;
                    CFG_RIGHT:  cr_reg <= cfg_wdata;
                    CFG_TOP:    ct_reg <= cfg_wdata;
                    CFG_BOTTOM: cb_reg <= cfg_wdata;
                    default:    cl_reg <= cl_reg;
                endcase
            end
            if (state_reg == ST_BUILD)
            begin
                px_reg          <= cx_reg;
                py_reg          <= cy_reg;
                prev_region_reg <= pair_reg.cur;
                ocnt_reg        <= lcnt;
                oidx_reg        <= '0;
            end
            if (state_reg == ST_SEND && m_tready)
            begin
                oidx_reg <= oidx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg       <= in_x;
            cy_reg       <= in_y;
            dx_reg       <= dx_in;
            dy_reg       <= dy_in;
            pair_reg.cur <= cur_in;
            pair_reg.prv <= s_tuser ? cur_in : prev_region_reg;
        end
        if (state_reg == ST_WAIT && mu_done)
        begin
            res_reg[job_reg] <= mu_result;
        end
        if (state_reg == ST_BUILD)
        begin
            for (int i = 0; i < MAX_PTS; i++)
            begin
                obx_reg[i] <= lpx[i];
                oby_reg[i] <= lpy[i];
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tlast  = (oidx_reg == ocnt_reg - 1'b1);
    assign m_tdata  = DW'({oby_reg[oidx_reg], obx_reg[oidx_reg]});

endmodule
